FILE: rtl/core/see_pkg.sv
`timescale 1ns / 1ps

package see_pkg;

  // word and field widths
  localparam int WORD_W = 32;
  localparam int SYM_W  = 8;
  localparam int STAT_W = 3;

  // result status codes
  localparam logic [STAT_W-1:0] ST_OK        = 3'd0;
  localparam logic [STAT_W-1:0] ST_DIVZERO   = 3'd1;
  localparam logic [STAT_W-1:0] ST_INVALID   = 3'd2;
  localparam logic [STAT_W-1:0] ST_EMPTY     = 3'd3;
  localparam logic [STAT_W-1:0] ST_UNDERFLOW = 3'd4;
  localparam logic [STAT_W-1:0] ST_OVERFLOW  = 3'd5;

  // expression characters
  localparam logic [SYM_W-1:0] CH_ZERO  = 8'h30;
  localparam logic [SYM_W-1:0] CH_NINE  = 8'h39;
  localparam logic [SYM_W-1:0] CH_PLUS  = 8'h2b;
  localparam logic [SYM_W-1:0] CH_MINUS = 8'h2d;
  localparam logic [SYM_W-1:0] CH_STAR  = 8'h2a;
  localparam logic [SYM_W-1:0] CH_SLASH = 8'h2f;

  // register word index (paddr[2])
  localparam logic REG_NOTATION = 1'b0;

  typedef enum logic [1:0] {
    ALU_ADD,
    ALU_SUB,
    ALU_MUL,
    ALU_DIV
  } alu_op_t;

  typedef struct packed {
    logic [SYM_W-1:0] symbol;
    logic             symbol_present;
    logic             last;
  } see_in_t;

  typedef struct packed {
    logic signed [WORD_W-1:0] value;
    logic [STAT_W-1:0]        status;
  } see_out_t;

  // request to the shared arithmetic unit
  typedef struct packed {
    logic              start;
    alu_op_t           op;
    logic [WORD_W-1:0] a;
    logic [WORD_W-1:0] b;
  } alu_req_t;

  // answer from the shared arithmetic unit
  typedef struct packed {
    logic              done;
    logic [WORD_W-1:0] result;
  } alu_rsp_t;

endpackage

FILE: rtl/core/see_alu.sv
`timescale 1ns / 1ps

module see_alu
  import see_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  alu_req_t req,
  output alu_rsp_t rsp
);

  localparam int STEPS = WORD_W;
  localparam int CNT_W = $clog2(STEPS);
  localparam int ADD_W = WORD_W + 2;
  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(STEPS - 1);

  typedef enum logic [2:0] {
    S_IDLE,
    S_ABS_A,
    S_ABS_B,
    S_DIV,
    S_FIX,
    S_MUL,
    S_DONE
  } state_t;

  state_t            state_r;
  logic [WORD_W-1:0] acc_r;
  logic [WORD_W-1:0] opa_r;
  logic [WORD_W-1:0] opb_r;
  logic              neg_r;
  logic [CNT_W-1:0]  cnt_r;
  logic [WORD_W-1:0] res_r;

  logic [ADD_W-1:0]  add_x;
  logic [ADD_W-1:0]  add_y;
  logic              add_sub;
  logic [ADD_W-1:0]  add_sum;
  logic [WORD_W:0]   rem_sh;

  // partial remainder shifted left with the next dividend bit
  assign rem_sh = {acc_r, opa_r[WORD_W-1]};

  // operand selection for the one shared adder
  always_comb begin
    add_x   = '0;
    add_y   = '0;
    add_sub = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        add_x   = {2'b00, req.a};
        add_y   = {2'b00, req.b};
        add_sub = (req.op == ALU_SUB);
      end
      S_ABS_A: begin
        add_y   = {2'b00, opa_r};
        add_sub = 1'b1;
      end
      S_ABS_B: begin
        add_y   = {2'b00, opb_r};
        add_sub = 1'b1;
      end
      S_DIV: begin
        add_x   = {1'b0, rem_sh};
        add_y   = {2'b00, opb_r};
        add_sub = 1'b1;
      end
      S_FIX: begin
        add_y   = {2'b00, opa_r};
        add_sub = 1'b1;
      end
      S_MUL: begin
        add_x   = {2'b00, acc_r};
        add_y   = {2'b00, opa_r};
      end
      S_DONE: begin
        add_sub = 1'b0;
      end
      default: begin
        add_sub = 1'b0;
      end
    endcase
  end

  assign add_sum = add_x + (add_y ^ {ADD_W{add_sub}}) + ADD_W'(add_sub);

  // sequencer: add and subtract in one step, multiply and divide bit by bit
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      unique case (state_r)
        S_IDLE: begin
          if (req.start) begin
            opa_r <= req.a;
            opb_r <= req.b;
            acc_r <= '0;
            cnt_r <= '0;
            neg_r <= req.a[WORD_W-1] ^ req.b[WORD_W-1];
            unique case (req.op)
              ALU_ADD, ALU_SUB: begin
                res_r   <= add_sum[WORD_W-1:0];
                state_r <= S_DONE;
              end
              ALU_MUL: state_r <= S_MUL;
              ALU_DIV: state_r <= S_ABS_A;
              default: state_r <= S_DONE;
            endcase
          end
        end
        S_ABS_A: begin
          if (opa_r[WORD_W-1]) begin
            opa_r <= add_sum[WORD_W-1:0];
          end
          state_r <= S_ABS_B;
        end
        S_ABS_B: begin
          if (opb_r[WORD_W-1]) begin
            opb_r <= add_sum[WORD_W-1:0];
          end
          state_r <= S_DIV;
        end
        S_DIV: begin
          // restoring step: keep the difference when it does not borrow
          if (!add_sum[ADD_W-1]) begin
            acc_r <= add_sum[WORD_W-1:0];
            opa_r <= {opa_r[WORD_W-2:0], 1'b1};
          end else begin
            acc_r <= rem_sh[WORD_W-1:0];
            opa_r <= {opa_r[WORD_W-2:0], 1'b0};
          end
          cnt_r <= cnt_r + CNT_W'(1);
          if (cnt_r == CNT_LAST) begin
            state_r <= S_FIX;
          end
        end
        S_FIX: begin
          // quotient sign from the operand signs
          res_r   <= neg_r ? add_sum[WORD_W-1:0] : opa_r;
          state_r <= S_DONE;
        end
        S_MUL: begin
          // shift-add, low word only
          if (opb_r[0]) begin
            acc_r <= add_sum[WORD_W-1:0];
          end
          opa_r <= {opa_r[WORD_W-2:0], 1'b0};
          opb_r <= {1'b0, opb_r[WORD_W-1:1]};
          cnt_r <= cnt_r + CNT_W'(1);
          if (cnt_r == CNT_LAST) begin
            res_r   <= opb_r[0] ? add_sum[WORD_W-1:0] : acc_r;
            state_r <= S_DONE;
          end
        end
        S_DONE: begin
          state_r <= S_IDLE;
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  assign rsp.done   = (state_r == S_DONE);
  assign rsp.result = res_r;

endmodule

FILE: rtl/core/stack_expression_evaluator.sv
`timescale 1ns / 1ps
// channel   ports                               direction  accepted when
// ---------------------------------------------------------------------------
// input     in_valid, in_ready, in_data         in         in_valid & in_ready
// result    out_valid, out_ready, out_data      out        out_valid & out_ready
// config    psel, penable, pwrite, paddr, ...   in         psel & penable & pwrite
//
// A digit is taken in S_IDLE; an operator goes on to S_LOAD and S_EXEC; the
// multiply and divide go one bit a cycle through the shared adder in see_alu.
// An item marked last then passes through S_FIN to load the result register.
// Reset (rst_n low, synchronous) empties the stack and clears the error;
// the stack memory itself is not cleared.
// A result waiting on out_ready does not block input; only a second
// finished result waits for the first to be taken.

module stack_expression_evaluator
  import see_pkg::*;
#(
  parameter int STACK_DEPTH = 64
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  see_in_t     in_data,
  output logic        out_valid,
  input  logic        out_ready,
  output see_out_t    out_data,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int AW = $clog2(STACK_DEPTH);
  localparam int CW = $clog2(STACK_DEPTH + 1);

  typedef enum logic [1:0] {
    S_IDLE,
    S_LOAD,
    S_EXEC,
    S_FIN
  } state_t;

  state_t            state_r;
  logic [CW-1:0]     count_r;
  logic [STAT_W-1:0] err_r;
  logic [WORD_W-1:0] tos_r;
  logic [WORD_W-1:0] rd_r;
  alu_op_t           op_r;
  logic              last_r;
  logic              notation_r;
  logic              out_valid_r;
  see_out_t          out_data_r;

  logic [WORD_W-1:0] stack_mem [STACK_DEPTH];

  logic              accept;
  logic              active;
  logic              is_digit;
  logic              is_op;
  logic              full;
  logic              few;
  logic [CW-1:0]     cnt_m1;
  logic [CW-1:0]     cnt_m2;
  logic              mem_we;
  logic [WORD_W-1:0] opnd_a;
  logic [WORD_W-1:0] opnd_b;
  logic              div_zero;
  logic [STAT_W-1:0] fin_status;
  logic              fin_fire;
  state_t            item_next;
  logic              cfg_wr;
  alu_req_t          alu_req;
  alu_rsp_t          alu_rsp;

  function automatic alu_op_t sym_to_op(input logic [SYM_W-1:0] sym);
    alu_op_t op;
    priority if (sym == CH_PLUS)  op = ALU_ADD;
    else if (sym == CH_MINUS)     op = ALU_SUB;
    else if (sym == CH_STAR)      op = ALU_MUL;
    else                          op = ALU_DIV;
    return op;
  endfunction

  // item decode
  assign accept   = in_valid && in_ready;
  assign active   = in_data.symbol_present && (err_r == ST_OK);
  assign is_digit = (in_data.symbol >= CH_ZERO) && (in_data.symbol <= CH_NINE);
  assign is_op    = (in_data.symbol == CH_PLUS) || (in_data.symbol == CH_MINUS) ||
                    (in_data.symbol == CH_STAR) || (in_data.symbol == CH_SLASH);
  assign full     = (count_r == CW'(STACK_DEPTH));
  assign few      = (count_r < CW'(2));
  assign cnt_m1   = count_r - CW'(1);
  assign cnt_m2   = count_r - CW'(2);

  // state after an item that needs no arithmetic
  assign item_next = in_data.last ? S_FIN : S_IDLE;

  // old top spills to memory on a push
  assign mem_we = accept && active && is_digit && !full && (count_r != '0);

  always_ff @(posedge clk) begin
    if (mem_we) begin
      stack_mem[cnt_m1[AW-1:0]] <= tos_r;
    end
    if (accept) begin
      rd_r <= stack_mem[cnt_m2[AW-1:0]];
    end
  end

  // operand order follows the notation
  assign opnd_a   = notation_r ? tos_r : rd_r;
  assign opnd_b   = notation_r ? rd_r : tos_r;
  assign div_zero = (op_r == ALU_DIV) && (opnd_b == '0);

  assign alu_req.start = (state_r == S_LOAD) && !div_zero;
  assign alu_req.op    = op_r;
  assign alu_req.a     = opnd_a;
  assign alu_req.b     = opnd_b;

  see_alu u_alu (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (alu_req),
    .rsp   (alu_rsp)
  );

  // status reported at expression end
  always_comb begin
    priority if (err_r != ST_OK) fin_status = err_r;
    else if (count_r == '0)       fin_status = ST_EMPTY;
    else                          fin_status = ST_OK;
  end

  // result register loads when it is free or being taken
  assign fin_fire = (state_r == S_FIN) && (!out_valid_r || out_ready);

  assign cfg_wr = psel && penable && pwrite && pready;

  // sequencer, stack count, error and result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      err_r       <= ST_OK;
      notation_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_wr && (paddr[2] == REG_NOTATION)) begin
        notation_r <= pwdata[0];
      end
      if (out_valid_r && out_ready && !fin_fire) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (accept) begin
            last_r  <= in_data.last;
            op_r    <= sym_to_op(in_data.symbol);
            if (active) begin
              priority if (is_digit) begin
                if (full) begin
                  err_r <= ST_OVERFLOW;
                end else begin
                  tos_r   <= WORD_W'(in_data.symbol - CH_ZERO);
                  count_r <= count_r + CW'(1);
                end
                state_r <= item_next;
              end else if (!is_op) begin
                err_r   <= ST_INVALID;
                state_r <= item_next;
              end else if (few) begin
                err_r   <= ST_UNDERFLOW;
                state_r <= item_next;
              end else begin
                state_r <= S_LOAD;
              end
            end else begin
              state_r <= item_next;
            end
          end
        end
        S_LOAD: begin
          if (div_zero) begin
            err_r   <= ST_DIVZERO;
            state_r <= last_r ? S_FIN : S_IDLE;
          end else begin
            state_r <= S_EXEC;
          end
        end
        S_EXEC: begin
          if (alu_rsp.done) begin
            tos_r   <= alu_rsp.result;
            count_r <= cnt_m1;
            state_r <= last_r ? S_FIN : S_IDLE;
          end
        end
        S_FIN: begin
          if (fin_fire) begin
            out_valid_r       <= 1'b1;
            out_data_r.status <= fin_status;
            out_data_r.value  <= (fin_status == ST_OK) ? tos_r : '0;
            count_r           <= '0;
            err_r             <= ST_OK;
            state_r           <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;
  assign pready    = 1'b1;
  assign prdata    = (paddr[2] == REG_NOTATION) ? {31'b0, notation_r} : '0;

endmodule

FILE: rtl/core/see_checker.sv
`timescale 1ns / 1ps

module see_checker
  import see_pkg::*;
(
  input logic     clk,
  input logic     rst_n,
  input logic     in_ready,
  input logic     out_valid,
  input logic     out_ready,
  input see_out_t out_data
);

  // a stalled result item holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result item changed while stalled");

  // status stays within the defined codes
  a_status_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_data.status <= ST_OVERFLOW)
    else $error("undefined status code");

  // any error or empty expression reports value zero
  a_err_value: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_data.status != ST_OK) |-> out_data.value == '0)
    else $error("nonzero value with error status");

  // reset drops any pending result
  a_reset_clear: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

  // input is open right after reset
  a_reset_ready: assert property (@(posedge clk)
    !rst_n |=> in_ready)
    else $error("input not ready after reset");

endmodule

bind stack_expression_evaluator see_checker u_see_checker (.*);

FILE: bench/tb.sv
`timescale 1ns / 1ps

module tb;
  import see_pkg::*;

  localparam int DEPTH        = 64;
  localparam int PHASE_ITEMS  = 300;
  localparam int DRAIN_CYCLES = 64;
  localparam int HOLD_CYCLES  = 600;
  localparam int NUM_PHASES   = 6;

  localparam logic [2:0] ADDR_NOTATION = {REG_NOTATION, 2'b00};
  localparam logic [2:0] ADDR_UNUSED   = {~REG_NOTATION, 2'b00};

  // per-item tag: typed-in expectation for directed rows
  typedef struct packed {
    logic     typed;
    see_out_t want;
  } tag_t;

  typedef struct packed {
    see_in_t  item;
    logic     typed;
    see_out_t want;
  } dir_row_t;

  logic        clk;
  logic        rst_n     = 1'b0;
  logic        in_valid  = 1'b0;
  see_in_t     in_data   = '0;
  logic        out_ready = 1'b0;
  logic        psel      = 1'b0;
  logic        penable   = 1'b0;
  logic        pwrite    = 1'b0;
  logic [2:0]  paddr     = '0;
  logic [31:0] pwdata    = '0;
  logic        in_ready;
  logic        out_valid;
  see_out_t    out_data;
  logic [31:0] prdata;
  logic        pready;

  stack_expression_evaluator u_top (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin
    #10_000_000;
    $display("Simulation FAILED");
    $finish;
  end

  // evaluator shadow state
  logic [31:0] opnd_stk [DEPTH];
  int          opnd_cnt    = 0;
  logic [2:0]  err_latched = ST_OK;
  logic        notation_q  = 1'b0;

  see_out_t  result_q [$];
  tag_t      tag_q [$];
  see_in_t   expr_q [$];
  dir_row_t  dir_rows [$];
  int        fail_cnt    = 0;
  int        item_cnt    = 0;
  int        in_calm     = 0;
  int        out_calm    = 0;
  int        hold_asks   = 0;
  int        hold_served = 0;

  task automatic report_mismatch(input string what);
    if (fail_cnt < 40) $display("%0t ns mismatch: %s", $time, what);
    fail_cnt++;
  endtask

  function automatic logic [7:0] dig(input int n);
    return CH_ZERO + 8'(n);
  endfunction

  // one character against the operand stack
  function automatic void apply_char(input logic [7:0] ch);
    logic [31:0] top_w, next_w, lhs, rhs, res;
    longint      quo;
    if (ch >= CH_ZERO && ch <= CH_NINE) begin
      if (opnd_cnt >= DEPTH) begin
        err_latched = ST_OVERFLOW;
        return;
      end
      opnd_stk[opnd_cnt] = {24'd0, ch - CH_ZERO};
      opnd_cnt++;
      return;
    end
    if (ch != CH_PLUS && ch != CH_MINUS && ch != CH_STAR && ch != CH_SLASH) begin
      err_latched = ST_INVALID;
      return;
    end
    if (opnd_cnt < 2) begin
      err_latched = ST_UNDERFLOW;
      return;
    end
    top_w  = opnd_stk[opnd_cnt-1];
    next_w = opnd_stk[opnd_cnt-2];
    // prefix takes the first pop as the left operand
    lhs = notation_q ? top_w : next_w;
    rhs = notation_q ? next_w : top_w;
    if (ch == CH_PLUS) begin
      res = lhs + rhs;
    end else if (ch == CH_MINUS) begin
      res = lhs - rhs;
    end else if (ch == CH_STAR) begin
      res = lhs * rhs;
    end else begin
      if (rhs == 32'd0) begin
        err_latched = ST_DIVZERO;
        return;
      end
      quo = longint'($signed(lhs)) / longint'($signed(rhs));
      res = quo[31:0];
    end
    opnd_cnt--;
    opnd_stk[opnd_cnt-1] = res;
  endfunction

  // returns 1 when the item closes an expression
  function automatic logic eval_item(input see_in_t d, output see_out_t r);
    r = '0;
    if (d.symbol_present && err_latched == ST_OK) apply_char(d.symbol);
    if (!d.last) return 1'b0;
    if (err_latched != ST_OK) begin
      r.status = err_latched;
    end else if (opnd_cnt == 0) begin
      r.status = ST_EMPTY;
    end else begin
      r.status = ST_OK;
      r.value  = opnd_stk[opnd_cnt-1];
    end
    opnd_cnt    = 0;
    err_latched = ST_OK;
    return 1'b1;
  endfunction

  // accepted input items feed the shadow evaluator
  always @(posedge clk) begin : in_mon
    see_out_t pred;
    tag_t     tag;
    logic     has;
    if (rst_n && in_valid && in_ready) begin
      tag = '0;
      if (tag_q.size() > 0) tag = tag_q.pop_front();
      has = eval_item(in_data, pred);
      if (has) result_q.push_back(tag.typed ? tag.want : pred);
    end
  end

  // accepted results against the oldest expectation
  always @(posedge clk) begin : out_chk
    see_out_t want;
    if (rst_n && out_valid && out_ready) begin
      if (result_q.size() == 0) begin
        report_mismatch($sformatf("unexpected result value %0d status %0d",
                                  out_data.value, out_data.status));
      end else begin
        want = result_q.pop_front();
        if (out_data.value !== want.value)
          report_mismatch($sformatf("value %0d, want %0d", out_data.value, want.value));
        if (out_data.status !== want.status)
          report_mismatch($sformatf("status %0d, want %0d", out_data.status, want.status));
      end
    end
  end

  // mostly short gaps, a few long ones, and calm stretches with none
  function automatic int pick_gap(ref int calm);
    int r;
    if (calm > 0) begin
      calm--;
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 2) begin
      calm = $urandom_range(30, 120);
      return 0;
    end
    if (r < 50) return 0;
    if (r < 82) return $urandom_range(1, 3);
    if (r < 96) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // result side: random stalls plus a long hold once per phase
  initial begin : out_drv
    int g;
    @(posedge clk);
    forever begin
      if (hold_asks != hold_served) begin
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_served++;
      end else begin
        out_ready <= 1'b1;
        repeat ($urandom_range(1, 12)) @(posedge clk);
        g = pick_gap(out_calm);
        if (g > 0) begin
          out_ready <= 1'b0;
          repeat (g) @(posedge clk);
        end
      end
    end
  end

  task automatic send_item(input see_in_t d, input tag_t tag);
    int gap;
    gap = pick_gap(in_calm);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    tag_q.push_back(tag);
    in_valid <= 1'b1;
    in_data  <= d;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    if (d.symbol_present || d.last) item_cnt++;
  endtask

  task automatic apb_write(input logic [2:0] addr, input logic [31:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= data;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  task automatic verify_notation();
    logic [31:0] rd;
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= ADDR_NOTATION;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    rd = prdata;
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
    if (rd !== {31'd0, notation_q})
      report_mismatch($sformatf("notation reads %0h, want %0d", rd, notation_q));
  endtask

  task automatic wait_idle();
    while (result_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // only written once the block has drained
  task automatic set_notation(input logic v);
    wait_idle();
    apb_write(ADDR_NOTATION, {31'($urandom), v});
    notation_q = v;
    apb_write(ADDR_UNUSED, $urandom);
    verify_notation();
  endtask

  function automatic void add_row(input logic [7:0] ch, input logic pres, input logic lst,
                                  input logic typed, input logic signed [31:0] val,
                                  input logic [2:0] st);
    dir_rows.push_back({ch, pres, lst, typed, val, st});
  endfunction

  function automatic void push_sym(input logic [7:0] ch);
    expr_q.push_back({ch, 1'b1, 1'b0});
  endfunction

  function automatic logic [7:0] rand_op();
    case ($urandom_range(0, 3))
      0: return CH_PLUS;
      1: return CH_MINUS;
      2: return CH_STAR;
      default: return CH_SLASH;
    endcase
  endfunction

  function automatic logic [7:0] rand_junk();
    logic [7:0] ch;
    do begin
      ch = 8'($urandom);
    end while ((ch >= CH_ZERO && ch <= CH_NINE) || ch == CH_PLUS || ch == CH_MINUS ||
               ch == CH_STAR || ch == CH_SLASH);
    return ch;
  endfunction

  // random expression in stack order, valid for either notation
  function automatic void gen_wellformed(input int n_ops, input logic leave_extra);
    int depth, pushed;
    depth  = 0;
    pushed = 0;
    while (pushed < n_ops + 1 || depth > 1) begin
      if (depth < 2 || (pushed < n_ops + 1 && $urandom_range(0, 1) == 0)) begin
        push_sym(dig($urandom_range(0, 9)));
        depth++;
        pushed++;
      end else begin
        push_sym(rand_op());
        depth--;
        if (leave_extra && depth > 1 && $urandom_range(0, 3) == 0) break;
      end
    end
  endfunction

  // 8^10 * 2 wraps to the most negative word
  function automatic void push_min_word();
    push_sym(dig(8));
    repeat (9) begin
      push_sym(dig(8));
      push_sym(CH_STAR);
    end
    push_sym(dig(2));
    push_sym(CH_STAR);
  endfunction

  // minus one, operand order follows the notation
  function automatic void push_minus_one();
    push_sym(dig(notation_q ? 1 : 0));
    push_sym(dig(notation_q ? 0 : 1));
    push_sym(CH_MINUS);
  endfunction

  // close the expression with a last flag or a bare end marker
  function automatic void finish_expr();
    see_in_t tail;
    if ($urandom_range(0, 9) == 0)
      expr_q.insert($urandom_range(0, expr_q.size()), {8'($urandom), 1'b0, 1'b0});
    if (expr_q.size() > 0 && expr_q[expr_q.size()-1].symbol_present &&
        $urandom_range(0, 2) != 0) begin
      tail      = expr_q.pop_back();
      tail.last = 1'b1;
      expr_q.push_back(tail);
    end else begin
      expr_q.push_back({8'($urandom), 1'b0, 1'b1});
    end
  endfunction

  function automatic void build_expr();
    int kind;
    expr_q.delete();
    kind = $urandom_range(0, 99);
    if (kind < 62) begin
      gen_wellformed(($urandom_range(0, 99) < 85) ? $urandom_range(0, 6) : $urandom_range(7, 40),
                     $urandom_range(0, 7) == 0);
    end else if (kind < 70) begin
      // fill the stack close to the brim, at times past it
      repeat ($urandom_range(62, 66)) push_sym(dig($urandom_range(0, 9)));
      if ($urandom_range(0, 1) == 0) push_sym(rand_op());
    end else if (kind < 76) begin
      // most negative over minus one
      if (notation_q) begin
        push_minus_one();
        push_min_word();
      end else begin
        push_min_word();
        push_minus_one();
      end
      push_sym(CH_SLASH);
      if ($urandom_range(0, 1) == 0) begin
        push_sym(dig($urandom_range(1, 9)));
        push_sym(rand_op());
      end
    end else if (kind < 88) begin
      // noise: any byte, present or not
      repeat ($urandom_range(1, 8)) expr_q.push_back({8'($urandom), 1'($urandom), 1'b0});
    end else if (kind < 97) begin
      // broken sequence
      gen_wellformed($urandom_range(1, 6), 1'b0);
      case ($urandom_range(0, 2))
        0: expr_q.push_front({rand_op(), 1'b1, 1'b0});
        1: expr_q.insert($urandom_range(0, expr_q.size()), {rand_junk(), 1'b1, 1'b0});
        default: void'(expr_q.pop_front());
      endcase
    end
    finish_expr();
  endfunction

  initial begin : main
    logic phase_note [NUM_PHASES];
    int   phase_end;
    phase_note = '{1'b1, 1'b0, 1'b0, 1'b1, 1'b0, 1'b1};

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    verify_notation();

    // directed rows, postfix after reset
    add_row(8'h00, 1'b0, 1'b1, 1'b1, 32'sd0, ST_EMPTY);
    add_row(dig(9), 1'b1, 1'b0, 1'b0, 32'sd0, ST_OK);
    add_row(dig(9), 1'b1, 1'b0, 1'b0, 32'sd0, ST_OK);
    add_row(CH_STAR, 1'b1, 1'b1, 1'b1, 32'sd81, ST_OK);
    add_row(dig(7), 1'b1, 1'b0, 1'b0, 32'sd0, ST_OK);
    add_row(dig(2), 1'b1, 1'b0, 1'b0, 32'sd0, ST_OK);
    add_row(CH_MINUS, 1'b1, 1'b0, 1'b0, 32'sd0, ST_OK);
    add_row(dig(3), 1'b1, 1'b0, 1'b0, 32'sd0, ST_OK);
    add_row(CH_SLASH, 1'b1, 1'b1, 1'b0, 32'sd0, ST_OK);
    // divide by zero
    add_row(dig(4), 1'b1, 1'b0, 1'b0, 32'sd0, ST_OK);
    add_row(dig(0), 1'b1, 1'b0, 1'b0, 32'sd0, ST_OK);
    add_row(CH_SLASH, 1'b1, 1'b1, 1'b1, 32'sd0, ST_DIVZERO);
    // invalid byte, then the latched error hides the digit
    add_row(8'hff, 1'b1, 1'b0, 1'b0, 32'sd0, ST_OK);
    add_row(dig(5), 1'b1, 1'b0, 1'b0, 32'sd0, ST_OK);
    add_row(8'h00, 1'b0, 1'b1, 1'b1, 32'sd0, ST_INVALID);
    // underflow on an empty stack
    add_row(CH_PLUS, 1'b1, 1'b1, 1'b1, 32'sd0, ST_UNDERFLOW);
    // zero byte present on the last item
    add_row(dig(1), 1'b1, 1'b0, 1'b0, 32'sd0, ST_OK);
    add_row(dig(2), 1'b1, 1'b0, 1'b0, 32'sd0, ST_OK);
    add_row(8'h00, 1'b1, 1'b1, 1'b1, 32'sd0, ST_INVALID);
    // leftover operands, bare marker in between does nothing
    add_row(dig(3), 1'b1, 1'b0, 1'b0, 32'sd0, ST_OK);
    add_row(dig(4), 1'b1, 1'b0, 1'b0, 32'sd0, ST_OK);
    add_row(CH_PLUS, 1'b1, 1'b0, 1'b0, 32'sd0, ST_OK);
    add_row(8'h5a, 1'b0, 1'b0, 1'b0, 32'sd0, ST_OK);
    add_row(dig(6), 1'b1, 1'b1, 1'b1, 32'sd6, ST_OK);
    add_row(8'hff, 1'b0, 1'b1, 1'b1, 32'sd0, ST_EMPTY);

    foreach (dir_rows[i]) send_item(dir_rows[i].item, {dir_rows[i].typed, dir_rows[i].want});
    in_valid <= 1'b0;

    // random phases over both notations
    phase_end = item_cnt;
    for (int p = 0; p < NUM_PHASES; p++) begin
      set_notation(phase_note[p]);
      hold_asks++;
      phase_end += PHASE_ITEMS;
      while (item_cnt < phase_end) begin
        build_expr();
        foreach (expr_q[i]) send_item(expr_q[i], '0);
      end
      in_valid <= 1'b0;
    end

    wait_idle();
    if (fail_cnt == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

FILE: stack_expression_evaluator.f
rtl/core/see_pkg.sv
rtl/core/see_alu.sv
rtl/core/stack_expression_evaluator.sv
rtl/core/see_checker.sv
bench/tb.sv
